[hw/rtl/multi_stream_length_deframer_core_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef MULTI_STREAM_LENGTH_DEFRAMER_CORE_MACROS_SVH
`define MULTI_STREAM_LENGTH_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/msld_pkg.sv]
package msld_pkg;

    localparam int unsigned STREAM_COUNT = 256;
    // Only stream numbers that fit the 8-bit stream field can ever be stored.
    localparam int unsigned MEM_DEPTH = (STREAM_COUNT < 256) ? STREAM_COUNT : 256;
    localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);

    localparam logic [3:0] HDR_BYTES = 4'd9;
    localparam logic [3:0] LEN_HI_POS = 4'd6;
    localparam logic [3:0] POS_IDLE = 4'd0;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    typedef struct packed {
        logic [15:0] left;
        logic [7:0]  hi;
        logic [3:0]  pos;
    } prog_t;

    localparam int unsigned PROG_W = $bits(prog_t);

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       is_header;
        logic       frame_start;
        logic       frame_end;
        logic       aborted;
    } result_t;

endpackage

[hw/rtl/multi_stream_length_deframer_core.sv]
// Length-prefixed frame deframer for many interleaved connections.
// Requests enter on the byte channel (byte_valid/byte_ready): func selects a
// data byte or a close event, stream_id names the connection. Each data byte
// comes back on the result channel (result_valid/result_ready) with header,
// frame start and frame end marks; a close on a connection that is inside a
// frame returns one abort result, a close on an idle connection returns none.
// A request is accepted, its connection state is read from the progress RAM,
// updated in the update stage, written back and registered into the result
// stage. One request per cycle is sustained while results are taken,
// including back-to-back requests on the same connection, which are served
// by a write-to-read bypass around the RAM.
// When the receiver stalls, the result register holds; a request in the update
// stage waits, and while one waits byte_ready drops until the result is taken.
// Reset clears a per-connection valid flag, so every connection starts idle
// with no clearing pass; requests are taken from the first cycle after reset.
`include "multi_stream_length_deframer_core_macros.svh"

module multi_stream_length_deframer_core
    import msld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic       func,
    input  logic [7:0] stream_id,
    input  logic [7:0] data_byte,
    input  logic       chunk_last,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_stream,
    output logic [7:0] out_byte,
    output logic       is_header,
    output logic       frame_start,
    output logic       frame_end,
    output logic       aborted
);

    logic              accept;
    logic [ADDR_W-1:0] rd_addr;
    logic              in_range;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_func_reg;
    logic [7:0]        s1_sid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_range_reg;
    logic              s1_fire;

    logic [MEM_DEPTH-1:0] valid_reg;
    logic                 vld_rd_reg;
    logic                 byp_hit_reg;
    prog_t                byp_word_reg;

    logic [PROG_W-1:0] ram_rdata;
    prog_t             cur;
    prog_t             nxt;
    result_t           res;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_stream_reg;
    result_t           out_res_reg;

    // The stream number only reaches the framer for the first time here.
    assign in_range = ({1'b0, stream_id} < 9'(MEM_DEPTH));
    assign rd_addr = stream_id[ADDR_W-1:0];
    assign s1_fire = s1_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !s1_valid_reg || s1_fire;
    assign accept = byte_valid && byte_ready;

    assign wr_en = s1_fire && s1_range_reg;
    assign wr_addr = s1_sid_reg[ADDR_W-1:0];

    msld_ram #(
        .WIDTH (PROG_W),
        .DEPTH (MEM_DEPTH)
    ) u_prog_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (nxt),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // A write in the same cycle as the read is missed by the RAM; take it from
    // the bypass. Entries never written since reset read as idle.
    always_comb
    begin
        if (byp_hit_reg)
        begin
            cur = byp_word_reg;
        end
        else if (vld_rd_reg)
        begin
            cur = prog_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    msld_step u_step (
        .func      (s1_func_reg),
        .data_byte (s1_byte_reg),
        .cur       (cur),
        .nxt       (nxt),
        .res       (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = s1_range_reg && res.emit;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func;
            s1_sid_reg <= stream_id;
            s1_byte_reg <= data_byte;
            s1_range_reg <= in_range;
            vld_rd_reg <= valid_reg[rd_addr];
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
            byp_word_reg <= nxt;
        end
        if (s1_fire)
        begin
            out_stream_reg <= s1_sid_reg;
            out_res_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_stream = out_stream_reg;
    assign out_byte = out_res_reg.data;
    assign is_header = out_res_reg.is_header;
    assign frame_start = out_res_reg.frame_start;
    assign frame_end = out_res_reg.frame_end;
    assign aborted = out_res_reg.aborted;

    `MSLD_ASSERT_NOW(a_abort_clean, result_valid && aborted,
        !is_header && !frame_start && !frame_end && (out_byte == 8'd0),
        "abort result carries frame marks or data")
    `MSLD_ASSERT_NOW(a_start_in_header, result_valid && frame_start, is_header,
        "frame start outside the header")
    `MSLD_ASSERT_NOW(a_pos_bound, wr_en, nxt.pos <= HDR_BYTES,
        "header position written beyond the body state")
    `MSLD_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_fire, s1_valid_reg,
        "stalled request dropped from the update stage")
    `MSLD_ASSERT_NOW(a_ready_when_empty, !s1_valid_reg, byte_ready,
        "request refused with an empty update stage")

endmodule

[hw/rtl/msld_ram.sv]
module msld_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/msld_step.sv]
module msld_step
    import msld_pkg::*;
(
    input  logic       func,
    input  logic [7:0] data_byte,
    input  prog_t      cur,
    output prog_t      nxt,
    output result_t    res
);

    logic [3:0]  pos_inc;
    logic [15:0] left_dec;
    prog_t       hdr_prog;

    always_comb
    begin
        pos_inc = cur.pos + 4'd1;
        left_dec = cur.left - 16'd1;
        hdr_prog = cur;
        hdr_prog.pos = pos_inc;
        if (cur.pos == LEN_HI_POS)
        begin
            hdr_prog.hi = data_byte;
        end
        else if (cur.pos == LEN_HI_POS + 4'd1)
        begin
            hdr_prog.left = {cur.hi, data_byte};
        end

        nxt = cur;
        res = '0;
        res.data = data_byte;

        if (func == FUNC_CLOSE)
        begin
            res.data = 8'd0;
            if (cur.pos != POS_IDLE)
            begin
                nxt = '0;
                res.emit = 1'b1;
                res.aborted = 1'b1;
            end
        end
        else if (cur.pos < HDR_BYTES)
        begin
            res.emit = 1'b1;
            res.is_header = 1'b1;
            res.frame_start = (cur.pos == POS_IDLE);
            // The last header byte closes the frame at once when the body is empty.
            if (pos_inc == HDR_BYTES && hdr_prog.left == 16'd0)
            begin
                res.frame_end = 1'b1;
                nxt = '0;
            end
            else
            begin
                nxt = hdr_prog;
            end
        end
        else
        begin
            res.emit = 1'b1;
            if (left_dec == 16'd0)
            begin
                res.frame_end = 1'b1;
                nxt = '0;
            end
            else
            begin
                nxt.pos = HDR_BYTES;
                nxt.left = left_dec;
            end
        end
    end

endmodule

[tb/tb_multi_stream_length_deframer_core.sv]
module tb_multi_stream_length_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import msld_pkg::*;

    localparam int POOL = 4;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic       func;
        logic [7:0] sid;
        logic [7:0] data;
        logic       chunk_end;
    } byte_req_t;

    typedef struct packed {
        logic [7:0] stream;
        logic [7:0] data;
        logic       hdr;
        logic       sof;
        logic       eof;
        logic       abrt;
    } marked_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    logic       func = FUNC_DATA;
    logic [7:0] stream_id = 8'd0;
    logic [7:0] data_byte = 8'd0;
    logic       chunk_last = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] out_stream;
    logic [7:0] out_byte;
    logic       is_header;
    logic       frame_start;
    logic       frame_end;
    logic       aborted;

    byte_req_t   rx_bytes_q[$];
    marked_res_t expected_marked_q[$];
    // Every connection starts idle after reset.
    prog_t       conn_prog [0:255] = '{default: '0};

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    bit stall_req = 1'b0;
    int stall_left = 0;

    // Frame generator state, one entry per connection in the active pool.
    logic [7:0] slot_sid [0:POOL-1];
    logic [7:0] slot_hdr [0:POOL-1][0:8];
    int         slot_total [0:POOL-1];
    int         slot_idx [0:POOL-1];
    bit         slot_live [0:POOL-1];
    bit         slot_close [0:POOL-1];

    multi_stream_length_deframer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .func         (func),
        .stream_id    (stream_id),
        .data_byte    (data_byte),
        .chunk_last   (chunk_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_stream   (out_stream),
        .out_byte     (out_byte),
        .is_header    (is_header),
        .frame_start  (frame_start),
        .frame_end    (frame_end),
        .aborted      (aborted)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Advances the framing state of one connection and queues the result it gives.
    function automatic void predict_deframe(input byte_req_t rq);
        prog_t       p;
        marked_res_t res;
        if (int'(rq.sid) >= STREAM_COUNT)
            return;
        p = conn_prog[rq.sid];
        res = '0;
        res.stream = rq.sid;
        if (rq.func == FUNC_CLOSE)
        begin
            if (p.pos != POS_IDLE)
            begin
                conn_prog[rq.sid] = '0;
                res.abrt = 1'b1;
                expected_marked_q.push_back(res);
            end
        end
        else if (p.pos < HDR_BYTES)
        begin
            res.data = rq.data;
            res.hdr = 1'b1;
            res.sof = (p.pos == POS_IDLE);
            if (p.pos == LEN_HI_POS)
                p.hi = rq.data;
            else if (p.pos == LEN_HI_POS + 4'd1)
                p.left = {p.hi, rq.data};
            p.pos = p.pos + 4'd1;
            if (p.pos == HDR_BYTES && p.left == 16'd0)
            begin
                res.eof = 1'b1;
                p = '0;
            end
            conn_prog[rq.sid] = p;
            expected_marked_q.push_back(res);
        end
        else
        begin
            res.data = rq.data;
            p.left = p.left - 16'd1;
            if (p.left == 16'd0)
            begin
                res.eof = 1'b1;
                p = '0;
            end
            else
            begin
                p.pos = HDR_BYTES;
            end
            conn_prog[rq.sid] = p;
            expected_marked_q.push_back(res);
        end
    endfunction

    function automatic void push_req(input logic f, input logic [7:0] s,
                                     input logic [7:0] d, input logic c);
        rx_bytes_q.push_back({f, s, d, c});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            func <= FUNC_DATA;
            stream_id <= 8'd0;
            data_byte <= 8'd0;
            chunk_last <= 1'b0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                predict_deframe({func, stream_id, data_byte, chunk_last});
            if (!byte_valid || byte_ready)
            begin
                if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    byte_req_t rq;
                    rq = rx_bytes_q.pop_front();
                    byte_valid <= 1'b1;
                    func <= rq.func;
                    stream_id <= rq.sid;
                    data_byte <= rq.data;
                    chunk_last <= rq.chunk_end;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (stall_req)
            stall_left <= STALL_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        marked_res_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_marked_q.size() == 0)
                begin
                    report_mismatch($sformatf("result on stream %0d with nothing expected",
                                              out_stream));
                end
                else
                begin
                    want = expected_marked_q.pop_front();
                    if (out_stream !== want.stream)
                        report_mismatch($sformatf("out_stream got %0d want %0d",
                                                  out_stream, want.stream));
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("stream %0d out_byte got %02h want %02h",
                                                  want.stream, out_byte, want.data));
                    if (is_header !== want.hdr)
                        report_mismatch($sformatf("stream %0d is_header got %b want %b",
                                                  want.stream, is_header, want.hdr));
                    if (frame_start !== want.sof)
                        report_mismatch($sformatf("stream %0d frame_start got %b want %b",
                                                  want.stream, frame_start, want.sof));
                    if (frame_end !== want.eof)
                        report_mismatch($sformatf("stream %0d frame_end got %b want %b",
                                                  want.stream, frame_end, want.eof));
                    if (aborted !== want.abrt)
                        report_mismatch($sformatf("stream %0d aborted got %b want %b",
                                                  want.stream, aborted, want.abrt));
                end
            end
            result_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic queue_directed();
        logic [7:0] empty_hdr [0:8];
        logic [7:0] long_hdr [0:8];
        int i;
        empty_hdr = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h00, 8'h00, 8'h7F};
        long_hdr = '{8'hA5, 8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h10, 8'hFF, 8'hFF, 8'h00};
        // Empty body: the ninth header byte ends the frame.
        for (i = 0; i < 9; i++)
            push_req(FUNC_DATA, 8'd0, empty_hdr[i], i[0]);
        push_req(FUNC_CLOSE, 8'd0, 8'hFF, 1'b1);
        // Largest body length, cut short by a close in the body.
        for (i = 0; i < 9; i++)
            push_req(FUNC_DATA, 8'd255, long_hdr[i], 1'b0);
        push_req(FUNC_DATA, 8'd255, 8'hFF, 1'b1);
        push_req(FUNC_DATA, 8'd255, 8'h00, 1'b0);
        push_req(FUNC_CLOSE, 8'd255, 8'h00, 1'b0);
        // Close part way through a header.
        for (i = 0; i < 3; i++)
            push_req(FUNC_DATA, 8'd128, 8'(8'h11 * i), 1'b0);
        push_req(FUNC_CLOSE, 8'd128, 8'h00, 1'b1);
    endtask

    task automatic queue_random(input int count);
        int made;
        int k;
        int j;
        int lim;
        bit clash;
        logic [7:0] sid;
        logic [7:0] d;
        logic [15:0] len;
        // Start each pool connection idle; a close on an idle connection is silent.
        for (k = 0; k < POOL; k++)
        begin
            do
            begin
                slot_sid[k] = 8'($urandom_range(0, 255));
                clash = 1'b0;
                for (j = 0; j < k; j++)
                    if (slot_sid[j] == slot_sid[k])
                        clash = 1'b1;
            end while (clash);
            slot_live[k] = 1'b0;
            push_req(FUNC_CLOSE, slot_sid[k], 8'($urandom), 1'($urandom));
        end
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                sid = 8'($urandom_range(0, 255));
                push_req(FUNC_CLOSE, sid, 8'($urandom), 1'($urandom));
                made++;
                for (k = 0; k < POOL; k++)
                    if (slot_live[k] && slot_sid[k] == sid)
                        slot_live[k] = 1'b0;
            end
            else
            begin
                k = $urandom_range(0, POOL - 1);
                if (!slot_live[k])
                begin
                    j = $urandom_range(0, 99);
                    slot_close[k] = 1'b0;
                    if (j < 10)
                    begin
                        // Frame of random length followed by a close, usually before the frame is complete.
                        len = 16'($urandom);
                        lim = 9 + ((len < 16'd20) ? int'(len) : 20);
                        slot_total[k] = $urandom_range(1, lim);
                        slot_close[k] = 1'b1;
                    end
                    else if (j < 25)
                    begin
                        len = 16'd0;
                        slot_total[k] = 9;
                    end
                    else
                    begin
                        len = 16'($urandom_range(1, 12));
                        slot_total[k] = 9 + int'(len);
                    end
                    for (j = 0; j < 9; j++)
                        slot_hdr[k][j] = 8'($urandom);
                    slot_hdr[k][6] = len[15:8];
                    slot_hdr[k][7] = len[7:0];
                    slot_idx[k] = 0;
                    slot_live[k] = 1'b1;
                end
                if (slot_idx[k] < 9)
                    d = slot_hdr[k][slot_idx[k]];
                else
                    d = 8'($urandom);
                push_req(FUNC_DATA, slot_sid[k], d, $urandom_range(0, 3) == 0);
                made++;
                slot_idx[k]++;
                if (slot_idx[k] == slot_total[k])
                begin
                    slot_live[k] = 1'b0;
                    if (slot_close[k])
                    begin
                        push_req(FUNC_CLOSE, slot_sid[k], 8'($urandom), 1'($urandom));
                        made++;
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_bytes_q.size() != 0 || byte_valid || expected_marked_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 66;
        queue_directed();
        queue_random(280);
        wait_drained();

        send_idle_pct = 66;
        recv_idle_pct = 25;
        queue_random(270);
        wait_drained();

        // No idling; a long receiver hold-off backs the block up into its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(280);
        repeat (30) @(negedge clk);
        stall_req = 1'b1;
        @(negedge clk);
        stall_req = 1'b0;
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_marked_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_marked_q.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
